@@ sv/cfr_pkg.sv @@
// cfr_pkg: shared constants, types and the crc-8 fold for the cobs frame receiver
// no dependencies; imported by every module of the block but cfr_ram and cfr_checker
`timescale 1ns / 1ps

package cfr_pkg;

	localparam int DEF_MAX_DECODED = 16;
	localparam int DEF_MAX_ENCODED = 20;

	// packets parked between front and back; must be a power of two
	localparam int QUEUE_DEPTH = 4;

	localparam int HEADER_BYTES = 3;
	localparam int MIN_FRAME    = 4;

	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] DELIM_BYTE = 8'h00;
	localparam logic [7:0] FULL_CODE  = 8'hFF;
	localparam logic [7:0] ONE_CODE   = 8'h01;

	// one good packet waiting for the back end
	typedef struct packed {
		logic [7:0] msg_type;
		logic [7:0] seq_number;
		logic [7:0] declared_len;
		logic [7:0] pay_cnt;
		logic       len_mismatch;
	} desc_t;

	// one result transfer
	typedef struct packed {
		logic [7:0] msg_type;
		logic [7:0] seq_number;
		logic [7:0] declared_len;
		logic [7:0] payload_byte;
		logic       payload_present;
		logic [3:0] byte_index;
		logic       len_mismatch;
		logic       last_of_packet;
	} res_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr;
	} q_front_t;

	// queue status seen by the back end
	typedef struct packed {
		logic  valid;
		logic [$clog2(QUEUE_DEPTH)-1:0] rd_ptr;
		desc_t head;
	} q_back_t;

	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

@@ sv/cobs_crc8_frame_receiver_top.sv @@
// cobs_crc8_frame_receiver_top: cobs+crc-8 deframer, one transfer per payload byte (at least one)
// depends on cfr_pkg, cfr_ram, cfr_front, cfr_queue, cfr_back
//
//  channel | dir | tdata (low bit up)                              | tuser           | tlast
//  s_      | in  | rx_byte[7:0]                                    | -               | -
//  m_      | out | msg_type, seq_number, declared_len,             | payload_present | last_of_packet
//          |     | payload_byte, byte_index[3:0], len_mismatch, pad|                 |
//
// one line byte per cycle while s_tready is high; the front end decodes on the fly and
// the crc fold is byte wide; a good packet leaves at one transfer per cycle while m_tready
// is high, through the descriptor queue, a registered ram read and a two-entry output buffer
// s_tready drops only when all four ram buffers hold packets not yet read from the ram
// reset is asynchronous, active low; the decoded-byte ram needs no clearing pass
`timescale 1ns / 1ps

module cobs_crc8_frame_receiver_top import cfr_pkg::*; #(
	parameter int MAX_DECODED = DEF_MAX_DECODED,
	parameter int MAX_ENCODED = DEF_MAX_ENCODED
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// msg_type, seq_number, declared_len, payload_byte, byte_index, len_mismatch, zero pad
	output logic [39:0] m_tdata,
	output logic        m_tuser,   // payload_present
	output logic        m_tlast    // last_of_packet
);

	localparam int ADDR_W = $clog2(QUEUE_DEPTH) + $clog2(MAX_DECODED);

	q_front_t          q_front;
	q_back_t           q_back;
	logic              push, pop;
	desc_t             push_desc;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        wr_data, rd_data;
	res_t              res;

	cfr_front #(
		.MAX_DECODED(MAX_DECODED),
		.MAX_ENCODED(MAX_ENCODED)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_stat   (q_front),
		.push     (push),
		.push_desc(push_desc),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	cfr_ram #(
		.WIDTH(8),
		.DEPTH(1 << ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	cfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.front_stat(q_front),
		.back_stat (q_back)
	);

	cfr_back #(
		.MAX_DECODED(MAX_DECODED)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_back),
		.pop      (pop),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {3'b000, res.len_mismatch, res.byte_index, res.payload_byte,
		res.declared_len, res.seq_number, res.msg_type};
	assign m_tuser = res.payload_present;
	assign m_tlast = res.last_of_packet;

endmodule

@@ sv/cfr_ram.sv @@
// cfr_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ sv/cfr_front.sv @@
// cfr_front: cobs decoding, crc-8 tracking and frame checks on the receive side
// depends on cfr_pkg; writes decoded bytes into the shared ram, pushes packets to cfr_queue
`timescale 1ns / 1ps

module cfr_front import cfr_pkg::*; #(
	parameter int MAX_DECODED = DEF_MAX_DECODED,
	parameter int MAX_ENCODED = DEF_MAX_ENCODED
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] in_byte,
	input  q_front_t  q_stat,
	output logic      push,
	output desc_t     push_desc,
	output logic      wr_en,
	output logic [$clog2(QUEUE_DEPTH)+$clog2(MAX_DECODED)-1:0] wr_addr,
	output logic [7:0] wr_data
);

	localparam int IDX_W = $clog2(MAX_DECODED);
	localparam int DEC_W = $clog2(MAX_DECODED + 1);
	localparam int ENC_W = $clog2(MAX_ENCODED + 1);

	logic [ENC_W-1:0] enc_q, enc_d;
	logic [DEC_W-1:0] dec_q, dec_d;
	logic [7:0]       grp_q, grp_d;
	logic             full_q, full_d;
	logic             zp_q, zp_d;
	logic             bad_q, bad_d;
	logic [7:0]       crc_q, crc_d;
	logic [7:0]       last_q, type_q, seq_q, len_q;

	logic       acc;
	logic       st_req;
	logic [7:0] st_byte;
	logic       frame_ok;
	logic [7:0] pay;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;

	assign pay      = 8'(dec_q - DEC_W'(MIN_FRAME));
	assign frame_ok = (enc_q != '0) && !bad_q && (grp_q == 8'h00)
		&& (dec_q >= DEC_W'(MIN_FRAME)) && (last_q == crc_q);

	assign push_desc.msg_type     = type_q;
	assign push_desc.seq_number   = seq_q;
	assign push_desc.declared_len = len_q;
	assign push_desc.pay_cnt      = pay;
	assign push_desc.len_mismatch = (len_q != pay);

	assign wr_addr = {q_stat.wr_ptr, dec_q[IDX_W-1:0]};
	assign wr_data = st_byte;

	always_comb begin
		enc_d   = enc_q;
		dec_d   = dec_q;
		grp_d   = grp_q;
		full_d  = full_q;
		zp_d    = zp_q;
		bad_d   = bad_q;
		crc_d   = crc_q;
		st_req  = 1'b0;
		st_byte = 8'h00;
		push    = 1'b0;
		wr_en   = 1'b0;
		if (acc) begin
			if (in_byte == DELIM_BYTE || enc_q >= ENC_W'(MAX_ENCODED)) begin
				push  = (in_byte == DELIM_BYTE) && frame_ok;
				enc_d = '0;
				dec_d = '0;
				grp_d = 8'h00;
				full_d = 1'b0;
				zp_d  = 1'b0;
				bad_d = 1'b0;
				crc_d = 8'h00;
			end else begin
				enc_d = enc_q + ENC_W'(1);
				if (grp_q == 8'h00) begin
					// code byte: settle any owed zero, open the next group
					st_req = zp_q;
					full_d = (in_byte == FULL_CODE);
					grp_d  = in_byte - 8'h01;
					zp_d   = (in_byte == ONE_CODE);
				end else begin
					st_req  = 1'b1;
					st_byte = in_byte;
					grp_d   = grp_q - 8'h01;
					if (grp_q == 8'h01) begin
						zp_d = !full_q;
					end
				end
			end
		end
		if (st_req && !bad_q) begin
			if (dec_q >= DEC_W'(MAX_DECODED)) begin
				bad_d = 1'b1;
			end else begin
				wr_en = 1'b1;
				dec_d = dec_q + DEC_W'(1);
				// crc lags one byte behind the store
				if (dec_q != '0) begin
					crc_d = crc8_fold(crc_q, last_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q  <= '0;
			dec_q  <= '0;
			grp_q  <= 8'h00;
			full_q <= 1'b0;
			zp_q   <= 1'b0;
			bad_q  <= 1'b0;
			crc_q  <= 8'h00;
		end else begin
			enc_q  <= enc_d;
			dec_q  <= dec_d;
			grp_q  <= grp_d;
			full_q <= full_d;
			zp_q   <= zp_d;
			bad_q  <= bad_d;
			crc_q  <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_q <= st_byte;
			if (dec_q == DEC_W'(0)) begin
				type_q <= st_byte;
			end
			if (dec_q == DEC_W'(1)) begin
				seq_q <= st_byte;
			end
			if (dec_q == DEC_W'(2)) begin
				len_q <= st_byte;
			end
		end
	end

endmodule

@@ sv/cfr_queue.sv @@
// cfr_queue: packet descriptor fifo between front and back; its pointers name ram buffers
// depends on cfr_pkg
`timescale 1ns / 1ps

module cfr_queue import cfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  desc_t    push_desc,
	input  logic     pop,
	output q_front_t front_stat,
	output q_back_t  back_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign front_stat.full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign front_stat.wr_ptr = wp_q;
	assign back_stat.valid   = (cnt_q != '0);
	assign back_stat.rd_ptr  = rp_q;
	assign back_stat.head    = entry_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_desc;
		end
	end

endmodule

@@ sv/cfr_back.sv @@
// cfr_back: walks queued packets, reads payload from the ram, buffers results for output
// depends on cfr_pkg; reads the shared ram through its registered port
`timescale 1ns / 1ps

module cfr_back import cfr_pkg::*; #(
	parameter int MAX_DECODED = DEF_MAX_DECODED
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_back_t   q_stat,
	output logic      pop,
	output logic [$clog2(QUEUE_DEPTH)+$clog2(MAX_DECODED)-1:0] rd_addr,
	input  logic [7:0] rd_data,
	output logic      out_valid,
	input  logic      out_ready,
	output res_t      out_res
);

	localparam int IDX_W = $clog2(MAX_DECODED);

	logic [7:0] k_q;
	logic       v_s1;
	logic       ram_s1;
	res_t       res_s1;
	res_t       ob_q [2];
	logic       ob_wp_q, ob_rp_q;
	logic [1:0] ob_cnt_q;

	logic       issue, pay0, last_item, out_pop;
	logic [2:0] occ;
	res_t       res_new, res_fill;

	assign out_valid = (ob_cnt_q != 2'd0);
	assign out_res   = ob_q[ob_rp_q];
	assign out_pop   = out_valid && out_ready;

	// at most two results in flight or buffered
	assign occ   = {1'b0, ob_cnt_q} + {2'b00, v_s1};
	assign issue = q_stat.valid && (occ < (3'd2 + {2'b00, out_pop}));

	assign pay0      = (q_stat.head.pay_cnt == 8'h00);
	assign last_item = pay0 || ((k_q + 8'h01) == q_stat.head.pay_cnt);
	assign pop       = issue && last_item;
	assign rd_addr   = {q_stat.rd_ptr, IDX_W'(HEADER_BYTES) + IDX_W'(k_q)};

	always_comb begin
		res_new.msg_type        = q_stat.head.msg_type;
		res_new.seq_number      = q_stat.head.seq_number;
		res_new.declared_len    = q_stat.head.declared_len;
		res_new.payload_byte    = 8'h00;
		res_new.payload_present = !pay0;
		res_new.byte_index      = pay0 ? 4'h0 : k_q[3:0];
		res_new.len_mismatch    = q_stat.head.len_mismatch;
		res_new.last_of_packet  = last_item;
		res_fill                = res_s1;
		res_fill.payload_byte   = ram_s1 ? rd_data : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= 8'h00;
			v_s1     <= 1'b0;
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				k_q <= last_item ? 8'h00 : k_q + 8'h01;
			end
			if (v_s1) begin
				ob_wp_q <= !ob_wp_q;
			end
			if (out_pop) begin
				ob_rp_q <= !ob_rp_q;
			end
			if (v_s1 && !out_pop) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (out_pop && !v_s1) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			res_s1 <= res_new;
			ram_s1 <= !pay0;
		end
		if (v_s1) begin
			ob_q[ob_wp_q] <= res_fill;
		end
	end

endmodule

@@ sv/cfr_checker.sv @@
// cfr_checker: port-level checks on the result stream of the frame receiver
// no package needed; bound to cobs_crc8_frame_receiver_top below
`timescale 1ns / 1ps

module cfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// nothing is offered while in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// a packet without payload is a single transfer with zero data and index
	a_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[31:24] == 8'h00)
			&& (m_tdata[35:32] == 4'h0))
		else $error("bad form of payload-free result");

	// without payload the mismatch flag means a nonzero declared length
	a_no_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[36] == (m_tdata[23:16] != 8'h00))
		else $error("length mismatch flag wrong for empty payload");

endmodule

bind cobs_crc8_frame_receiver_top cfr_checker u_cfr_checker (.*);

@@ sim/cfr_packet_checker.sv @@
// cfr_packet_checker: watches both stream channels of the cobs crc-8 frame receiver,
// predicts every packet result from the accepted line bytes and compares field by field
// depends on cfr_pkg for the result struct and frame constants
`timescale 1ns / 1ps

module cfr_packet_checker import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	logic [7:0] decoded [DEF_MAX_DECODED];
	int         enc_seen;
	int         dec_seen;
	logic [7:0] group_left;
	logic       group_full;
	logic       zero_owed;
	logic       overflowed;
	logic [7:0] crc_acc;
	res_t       owed_results[$];

	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] v);
		logic [7:0] r;
		r = acc ^ v;
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	task automatic restart_frame();
		enc_seen   = 0;
		dec_seen   = 0;
		group_left = 8'h00;
		group_full = 1'b0;
		zero_owed  = 1'b0;
		overflowed = 1'b0;
		crc_acc    = 8'h00;
	endtask

	// crc trails one byte behind, so the newest byte is never folded in
	task automatic put_decoded(input logic [7:0] v);
		if (overflowed)
			return;
		if (dec_seen >= DEF_MAX_DECODED) begin
			overflowed = 1'b1;
			return;
		end
		if (dec_seen > 0)
			crc_acc = crc_next(crc_acc, decoded[dec_seen - 1]);
		decoded[dec_seen] = v;
		dec_seen++;
	endtask

	task automatic queue_packet();
		int   pay;
		int   n;
		res_t r;
		pay = dec_seen - MIN_FRAME;
		n   = (pay == 0) ? 1 : pay;
		for (int k = 0; k < n; k++) begin
			r.msg_type        = decoded[0];
			r.seq_number      = decoded[1];
			r.declared_len    = decoded[2];
			r.payload_present = (pay != 0);
			r.payload_byte    = (pay != 0) ? decoded[HEADER_BYTES + k] : 8'h00;
			r.byte_index      = (pay != 0) ? 4'(k) : 4'd0;
			r.len_mismatch    = (int'(decoded[2]) != pay);
			r.last_of_packet  = (k == n - 1);
			owed_results.push_back(r);
		end
	endtask

	task automatic take_line_byte(input logic [7:0] b);
		if (b == DELIM_BYTE) begin
			if (enc_seen > 0 && !overflowed && group_left == 0 && dec_seen >= MIN_FRAME &&
					decoded[dec_seen - 1] == crc_acc)
				queue_packet();
			restart_frame();
		end else if (enc_seen >= DEF_MAX_ENCODED) begin
			// byte past the encoded limit is lost and collection starts over
			restart_frame();
		end else begin
			enc_seen++;
			if (group_left == 0) begin
				if (zero_owed) begin
					put_decoded(8'h00);
					zero_owed = 1'b0;
				end
				group_full = (b == FULL_CODE);
				group_left = b - 8'd1;
				if (group_left == 0)
					zero_owed = 1'b1;
			end else begin
				put_decoded(b);
				group_left--;
				if (group_left == 0)
					zero_owed = !group_full;
			end
		end
	endtask

	task automatic report(input string msg);
		fail_count++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		got.msg_type        = m_tdata[7:0];
		got.seq_number      = m_tdata[15:8];
		got.declared_len    = m_tdata[23:16];
		got.payload_byte    = m_tdata[31:24];
		got.byte_index      = m_tdata[35:32];
		got.len_mismatch    = m_tdata[36];
		got.payload_present = m_tuser;
		got.last_of_packet  = m_tlast;
		if (owed_results.size() == 0) begin
			report($sformatf("result transfer with none owed, tdata %h", m_tdata));
			return;
		end
		want = owed_results.pop_front();
		check_field("msg_type", got.msg_type, want.msg_type);
		check_field("seq_number", got.seq_number, want.seq_number);
		check_field("declared_len", got.declared_len, want.declared_len);
		check_field("payload_byte", got.payload_byte, want.payload_byte);
		check_field("payload_present", 8'(got.payload_present), 8'(want.payload_present));
		check_field("byte_index", 8'(got.byte_index), 8'(want.byte_index));
		check_field("len_mismatch", 8'(got.len_mismatch), 8'(want.len_mismatch));
		check_field("last_of_packet", 8'(got.last_of_packet), 8'(want.last_of_packet));
	endtask

	initial begin
		fail_count   = 0;
		pending      = 0;
		restart_frame();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_frame();
			owed_results.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				take_line_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_result();
			pending = owed_results.size();
		end
	end

endmodule

@@ sim/tb_cobs_crc8_frame_receiver_top.sv @@
// tb_cobs_crc8_frame_receiver_top: drives cobs-encoded frames, good and broken, into the
// receiver with random gaps and output stalls; verdict comes from cfr_packet_checker
// depends on cfr_pkg, cobs_crc8_frame_receiver_top and cfr_packet_checker
`timescale 1ns / 1ps

module tb_cobs_crc8_frame_receiver_top import cfr_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;

	typedef logic [7:0] byte_q_t[$];

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending;
	int sent_count;
	int cycles;
	bit tx_burst;
	bit rx_burst;

	cobs_crc8_frame_receiver_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	cfr_packet_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// zeros are made common so that decoded data splits into many groups
	function automatic logic [7:0] rand_byte();
		return ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
	endfunction

	function automatic int rand_pay_cnt();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
	endfunction

	// type, seq, declared length (mostly honest), payload
	function automatic byte_q_t make_packet(input int pay_cnt);
		byte_q_t p;
		p.push_back(rand_byte());
		p.push_back(rand_byte());
		p.push_back(($urandom_range(0, 3) == 0) ? rand_byte() : 8'(pay_cnt));
		repeat (pay_cnt) p.push_back(rand_byte());
		return p;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// appends the crc, cobs-encodes and sends the frame with its delimiter
	task automatic send_frame(input byte_q_t body, input bit bad_crc, input bit cut_in_group);
		logic [7:0] crc;
		byte_q_t    line;
		int         code_at;
		crc = 8'h00;
		foreach (body[i]) crc = crc8_fold(crc, body[i]);
		if (bad_crc)
			crc ^= 8'($urandom_range(1, 255));
		body.push_back(crc);
		code_at = 0;
		line.push_back(8'h00);
		foreach (body[i]) begin
			if (body[i] == 8'h00) begin
				line[code_at] = 8'(line.size() - code_at);
				code_at = line.size();
				line.push_back(8'h00);
			end else begin
				line.push_back(body[i]);
			end
		end
		line[code_at] = 8'(line.size() - code_at);
		// a code byte whose group never completes
		if (cut_in_group)
			line.push_back(8'($urandom_range(2, 255)));
		foreach (line[i]) send_byte(line[i]);
		send_byte(DELIM_BYTE);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// output side: a stall of random length after each transfer, with bursts of none
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 19);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		byte_q_t frame;
		int      mode;
		int      frame_no;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty frame
		send_byte(DELIM_BYTE);
		// all-zero packet: crc is zero and the trailing zero must survive
		frame = {8'h00, 8'h00, 8'h00};
		send_frame(frame, 1'b0, 1'b0);
		// one payload byte but declared length 255
		frame = {8'hFF, 8'h5A, 8'hFF, 8'h80};
		send_frame(frame, 1'b0, 1'b0);
		// crc failure
		frame = {8'h01, 8'h02, 8'h00};
		send_frame(frame, 1'b1, 1'b0);
		// frame ends inside a group
		send_byte(8'h05);
		send_byte(8'h11);
		send_byte(DELIM_BYTE);
		// short frame
		send_byte(8'h03);
		send_byte(8'hAA);
		send_byte(8'hBB);
		send_byte(DELIM_BYTE);
		wait_for_drain();

		frame_no = 0;
		while (sent_count < 430) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			// each broken kind once up front, then mostly good packets
			if (frame_no < 6) begin
				mode = frame_no + 4;
			end else begin
				mode = $urandom_range(0, 12);
				if (mode > 9)
					mode = 0;
			end
			case (mode)
				4: begin
					frame = {};
					repeat ($urandom_range(0, 2)) frame.push_back(rand_byte());
					send_frame(frame, 1'b0, 1'b0);
				end
				5: send_frame(make_packet(rand_pay_cnt()), 1'b1, 1'b0);
				6: send_frame(make_packet(rand_pay_cnt()), 1'b0, 1'b1);
				// more decoded bytes than the store holds, crc still good
				7: send_frame(make_packet($urandom_range(13, 15)), 1'b0, 1'b0);
				8: begin
					// encoded limit overrun, then a good packet right behind it
					repeat (DEF_MAX_ENCODED + 1) send_byte(8'($urandom_range(1, 255)));
					send_frame(make_packet(rand_pay_cnt()), 1'b0, 1'b0);
				end
				9: begin
					repeat ($urandom_range(1, 12)) send_byte(rand_byte());
					send_byte(DELIM_BYTE);
				end
				default: send_frame(make_packet(rand_pay_cnt()), 1'b0, 1'b0);
			endcase
			if ($urandom_range(0, 9) == 0)
				send_byte(DELIM_BYTE);
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
			frame_no++;
		end

		wait_for_drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ cobs_crc8_frame_receiver_top.f @@
sv/cfr_pkg.sv
sv/cfr_ram.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/cobs_crc8_frame_receiver_top.sv
sv/cfr_checker.sv
sim/cfr_packet_checker.sv
sim/tb_cobs_crc8_frame_receiver_top.sv
